// ===== hdl/dtt_pkg.sv =====
// Shared constants, types and state encoding of the dirty tile tracker.
package dtt_pkg;

  localparam int GRID_COLS  = 80;
  localparam int GRID_ROWS  = 60;
  localparam int CELL_SIZE  = 8;
  localparam int CELL_SHIFT = $clog2(CELL_SIZE);
  localparam int NCELLS     = GRID_COLS * GRID_ROWS;
  localparam int SCR_W      = GRID_COLS * CELL_SIZE;
  localparam int SCR_H      = GRID_ROWS * CELL_SIZE;

  localparam int COL_W  = $clog2(GRID_COLS + 1);
  localparam int ROW_W  = $clog2(GRID_ROWS + 1);
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int X_W    = COL_W + CELL_SHIFT;
  localparam int Y_W    = ROW_W + CELL_SHIFT;
  localparam int WORD_W = 9;  // occupied bit on top of the eight cell bits

  localparam logic [7:0] DIRTY_BIT = 8'h40;
  localparam logic [7:0] KEEP_MASK = 8'h3f;
  localparam logic [7:0] HIGH_FLAG = 8'h80;
  localparam logic [7:0] VIEW_BITS = 8'h03;

  localparam logic [1:0] CMD_MARK      = 2'd0;
  localparam logic [1:0] CMD_FLUSH     = 2'd1;
  localparam logic [1:0] CMD_SET_OCC   = 2'd2;
  localparam logic [1:0] CMD_PAGE_CLR  = 2'd3;

  localparam logic [2:0] REG_VP_ENABLE = 3'd0;
  localparam logic [2:0] REG_VP_LEFT   = 3'd1;
  localparam logic [2:0] REG_VP_TOP    = 3'd2;
  localparam logic [2:0] REG_VP_RIGHT  = 3'd3;
  localparam logic [2:0] REG_VP_BOTTOM = 3'd4;

  typedef struct packed {
    logic [COL_W-1:0] col0;
    logic [COL_W-1:0] col1;
    logic [ROW_W-1:0] row0;
    logic [ROW_W-1:0] row1;
    logic             empty;
    logic             whole;
  } clip_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE,
    ST_MARK_RD, ST_MARK_WR,
    ST_OCC_RD, ST_OCC_WR,
    ST_SCAN_RD, ST_SCAN_CHK,
    ST_WID_RD, ST_WID_CHK,
    ST_HGT_RD, ST_HGT_CHK,
    ST_CLR_RD, ST_CLR_WR,
    ST_PUSH, ST_FINISH
  } state_t;

endpackage

// ===== hdl/dtt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/dtt_clip.sv =====
// Clips a pixel rectangle to the screen and converts it to a cell range.
module dtt_clip (
  input  logic signed [15:0] left,
  input  logic signed [15:0] top,
  input  logic signed [15:0] right,
  input  logic signed [15:0] bottom,
  output dtt_pkg::clip_t     clip_o
);
  import dtt_pkg::*;

  // low edge: negative to 0, past the screen to the cell count
  function automatic logic [8:0] clip_lo(logic signed [15:0] v, logic signed [17:0] px,
                                         logic [8:0] cells);
    logic signed [17:0] e;
    logic [8:0]         r;
    e = 18'(v);
    if (e < 0) begin
      r = '0;
    end else if (e > px - 18'sd1) begin
      r = cells;
    end else begin
      r = e[11:3];
    end
    return r;
  endfunction

  // high edge: round up to a cell edge, clamp to the screen
  function automatic logic [8:0] clip_hi(logic signed [15:0] v, logic signed [17:0] px,
                                         logic [8:0] cells);
    logic signed [17:0] e;
    logic [8:0]         r;
    e = 18'(v) + 18'(CELL_SIZE - 1);
    if (e <= 0) begin
      r = '0;
    end else if (e >= px) begin
      r = cells;
    end else begin
      r = e[11:3];
    end
    return r;
  endfunction

  always_comb begin
    clip_o.col0  = COL_W'(clip_lo(left,   18'(SCR_W), 9'(GRID_COLS)));
    clip_o.col1  = COL_W'(clip_hi(right,  18'(SCR_W), 9'(GRID_COLS)));
    clip_o.row0  = ROW_W'(clip_lo(top,    18'(SCR_H), 9'(GRID_ROWS)));
    clip_o.row1  = ROW_W'(clip_hi(bottom, 18'(SCR_H), 9'(GRID_ROWS)));
    clip_o.empty = (clip_o.col1 <= clip_o.col0) || (clip_o.row1 <= clip_o.row0);
    clip_o.whole = (left <= 16'sd0) && (top <= 16'sd0) &&
                   (clip_o.col1 == COL_W'(GRID_COLS)) && (clip_o.row1 == ROW_W'(GRID_ROWS));
  end

endmodule

// ===== hdl/dirty_tile_tracker_unit.sv =====
// Dirty tile tracker: grid of screen cells with mark, flush, occupancy and page commands.
//
// The block keeps one bit-field word per 8x8 screen cell (80x60 cells) in a single
// synchronous RAM, together with the cell's occupied bit. After reset it runs a
// clearing pass over every cell, one cell per cycle, before it takes its first
// request; configuration writes are taken throughout. It works on one request at
// a time on the one RAM: a mark, a set occupancy and the clearing of a found
// rectangle read each cell and write it back, while a flush only reads as it scans
// along the row, extends a run to the right and measures down the run's first
// column. Results leave through an output register, so the next request is taken
// while the last result still waits. A flush returns one result per coalesced
// rectangle, or one empty result when it finds none, every other request one empty
// result; the final result of a request carries last.
module dirty_tile_tracker_unit (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_cmd,
  input  logic signed [15:0]  in_rect_left,
  input  logic signed [15:0]  in_rect_top,
  input  logic signed [15:0]  in_rect_right,
  input  logic signed [15:0]  in_rect_bottom,
  input  logic [7:0]          in_mark_flags,
  input  logic                in_page,
  input  logic [12:0]         in_cell_index,
  input  logic                in_occupied_value,
  input  logic [5:0]          in_row_index,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_rect_valid,
  output logic [9:0]          out_x0,
  output logic [8:0]          out_y0,
  output logic [9:0]          out_x1,
  output logic [8:0]          out_y1,
  output logic                out_last,
  output logic                out_viewport_hit,
  output logic                out_page_whole_status,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [9:0]          cfg_data
);
  import dtt_pkg::*;

  state_t state_r, state_nxt;

  // held request
  logic [1:0]         req_cmd_r;
  logic signed [15:0] req_left_r, req_top_r, req_right_r, req_bottom_r;
  logic [7:0]         req_flags_r;
  logic               req_page_r;
  logic [12:0]        req_cell_r;
  logic               req_occ_r;
  logic [5:0]         req_row_r;

  // configuration
  logic       vp_en_r;
  logic [9:0] vp_left_r, vp_top_r, vp_right_r, vp_bottom_r;

  // flags
  logic [1:0] pw_r, pw_nxt;
  logic       any_dirty_r, any_dirty_nxt;
  logic       hit_r, hit_nxt;

  // walk counters
  logic [ADDR_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [COL_W-1:0]  cx_r, cx_nxt, col_r, col_nxt, start_r, start_nxt;
  logic [ROW_W-1:0]  cy_r, cy_nxt, hrow_r, hrow_nxt;

  // pending rectangle, sent once the next one or the end of the row is known
  logic           pend_v_r, pend_v_nxt;
  logic [X_W-1:0] pend_x0_r, pend_x0_nxt, pend_x1_r, pend_x1_nxt;
  logic [Y_W-1:0] pend_y0_r, pend_y0_nxt, pend_y1_r, pend_y1_nxt;

  // output register
  logic           out_valid_r, out_valid_nxt;
  logic           out_rv_r, out_rv_nxt, out_last_r, out_last_nxt;
  logic           out_hit_r, out_hit_nxt, out_pw_r, out_pw_nxt;
  logic [X_W-1:0] out_x0_r, out_x0_nxt, out_x1_r, out_x1_nxt;
  logic [Y_W-1:0] out_y0_r, out_y0_nxt, out_y1_r, out_y1_nxt;

  // RAM port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  clip_t clip;

  logic             slot_free, accept, vp_hit, rd_dirty;
  logic [7:0]       mark_bits;
  logic [ROW_W-1:0] scan_row;
  logic [10:0]      px_l, px_r, px_t, px_b;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(GRID_COLS) + ADDR_W'(c));
  endfunction

  function automatic logic in_span(logic [10:0] v, logic [9:0] lo, logic [9:0] hi);
    return ({1'b0, lo} <= v) && (v <= {1'b0, hi});
  endfunction

  dtt_clip u_clip (
    .left   (req_left_r),
    .top    (req_top_r),
    .right  (req_right_r),
    .bottom (req_bottom_r),
    .clip_o (clip)
  );

  dtt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NCELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign scan_row  = ROW_W'(req_row_r);
  assign rd_dirty  = (ram_rdata[7:0] & DIRTY_BIT) != 8'h00;

  // viewport overlap of the current mark cell: either edge inside the span
  assign px_l   = 11'({cx_r, {CELL_SHIFT{1'b0}}});
  assign px_r   = px_l + 11'(CELL_SIZE);
  assign px_t   = 11'({cy_r, {CELL_SHIFT{1'b0}}});
  assign px_b   = px_t + 11'(CELL_SIZE);
  assign vp_hit = vp_en_r &&
                  (in_span(px_l, vp_left_r, vp_right_r) || in_span(px_r, vp_left_r, vp_right_r)) &&
                  (in_span(px_t, vp_top_r, vp_bottom_r) || in_span(px_b, vp_top_r, vp_bottom_r));

  assign mark_bits = (req_flags_r[2] ? HIGH_FLAG : 8'h00) | (req_flags_r[0] ? 8'h02 : 8'h00) |
                     DIRTY_BIT | (vp_hit ? VIEW_BITS : 8'h00);

  // RAM address follows the walk that owns the current state
  always_comb begin
    case (state_r)
      ST_CLEAR:              ram_addr = clr_idx_r;
      ST_OCC_RD, ST_OCC_WR:  ram_addr = ADDR_W'(req_cell_r);
      ST_SCAN_RD, ST_WID_RD: ram_addr = cell_addr(scan_row, col_r);
      ST_HGT_RD:             ram_addr = cell_addr(hrow_r, start_r);
      default:               ram_addr = cell_addr(cy_r, cx_r);
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    pw_nxt        = pw_r;
    any_dirty_nxt = any_dirty_r;
    hit_nxt       = hit_r;
    clr_idx_nxt   = clr_idx_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    col_nxt       = col_r;
    start_nxt     = start_r;
    hrow_nxt      = hrow_r;
    pend_v_nxt    = pend_v_r;
    pend_x0_nxt   = pend_x0_r;
    pend_y0_nxt   = pend_y0_r;
    pend_x1_nxt   = pend_x1_r;
    pend_y1_nxt   = pend_y1_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rv_nxt    = out_rv_r;
    out_x0_nxt    = out_x0_r;
    out_y0_nxt    = out_y0_r;
    out_x1_nxt    = out_x1_r;
    out_y1_nxt    = out_y1_r;
    out_last_nxt  = out_last_r;
    out_hit_nxt   = out_hit_r;
    out_pw_nxt    = out_pw_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = '0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_idx_r == ADDR_W'(NCELLS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        pend_v_nxt = 1'b0;
        unique case (req_cmd_r)
          CMD_MARK: begin
            if (pw_r[req_page_r] || clip.empty) begin
              state_nxt = ST_FINISH;
            end else begin
              if (clip.whole) begin
                pw_nxt[req_page_r] = 1'b1;
              end
              cx_nxt    = clip.col0;
              cy_nxt    = clip.row0;
              state_nxt = ST_MARK_RD;
            end
          end
          CMD_FLUSH: begin
            if (!any_dirty_r || 9'(req_row_r) >= 9'(GRID_ROWS)) begin
              state_nxt = ST_FINISH;
            end else begin
              // the last grid row closes the frame
              if (9'(req_row_r) == 9'(GRID_ROWS - 1)) begin
                any_dirty_nxt = 1'b0;
              end
              col_nxt   = '0;
              state_nxt = ST_SCAN_RD;
            end
          end
          CMD_SET_OCC: begin
            state_nxt = (req_cell_r < 13'(NCELLS)) ? ST_OCC_RD : ST_FINISH;
          end
          CMD_PAGE_CLR: begin
            pw_nxt[req_page_r] = 1'b0;
            state_nxt = ST_FINISH;
          end
          default: state_nxt = ST_FINISH;
        endcase
      end

      ST_MARK_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_MARK_WR;
      end

      ST_MARK_WR: begin
        // occupied cells ignore marks
        if (!ram_rdata[8]) begin
          ram_we        = 1'b1;
          ram_wdata     = {1'b0, ram_rdata[7:0] | mark_bits};
          any_dirty_nxt = 1'b1;
          if (vp_hit) begin
            hit_nxt = 1'b1;
          end
        end
        if (cx_r + 1'b1 < clip.col1) begin
          cx_nxt    = cx_r + 1'b1;
          state_nxt = ST_MARK_RD;
        end else if (cy_r + 1'b1 < clip.row1) begin
          cx_nxt    = clip.col0;
          cy_nxt    = cy_r + 1'b1;
          state_nxt = ST_MARK_RD;
        end else begin
          state_nxt = ST_FINISH;
        end
      end

      ST_OCC_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_OCC_WR;
      end

      ST_OCC_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {req_occ_r, ram_rdata[7:0]};
        state_nxt = ST_FINISH;
      end

      ST_SCAN_RD: begin
        if (col_r == COL_W'(GRID_COLS)) begin
          state_nxt = ST_FINISH;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_SCAN_CHK;
        end
      end

      ST_SCAN_CHK: begin
        col_nxt = col_r + 1'b1;
        if (rd_dirty) begin
          start_nxt = col_r;
          state_nxt = ST_WID_RD;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end

      // extend the run to the right; col ends one past the run
      ST_WID_RD: begin
        if (col_r == COL_W'(GRID_COLS)) begin
          hrow_nxt  = scan_row + 1'b1;
          state_nxt = ST_HGT_RD;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_WID_CHK;
        end
      end

      ST_WID_CHK: begin
        if (rd_dirty) begin
          col_nxt   = col_r + 1'b1;
          state_nxt = ST_WID_RD;
        end else begin
          hrow_nxt  = scan_row + 1'b1;
          state_nxt = ST_HGT_RD;
        end
      end

      // measure down the first column of the run
      ST_HGT_RD: begin
        if (hrow_r == ROW_W'(GRID_ROWS)) begin
          cx_nxt    = start_r;
          cy_nxt    = scan_row;
          state_nxt = ST_CLR_RD;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_HGT_CHK;
        end
      end

      ST_HGT_CHK: begin
        if (rd_dirty) begin
          hrow_nxt  = hrow_r + 1'b1;
          state_nxt = ST_HGT_RD;
        end else begin
          cx_nxt    = start_r;
          cy_nxt    = scan_row;
          state_nxt = ST_CLR_RD;
        end
      end

      ST_CLR_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_CLR_WR;
      end

      ST_CLR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {ram_rdata[8], ram_rdata[7:0] & KEEP_MASK};
        if (cx_r + 1'b1 < col_r) begin
          cx_nxt    = cx_r + 1'b1;
          state_nxt = ST_CLR_RD;
        end else if (cy_r + 1'b1 < hrow_r) begin
          cx_nxt    = start_r;
          cy_nxt    = cy_r + 1'b1;
          state_nxt = ST_CLR_RD;
        end else begin
          state_nxt = ST_PUSH;
        end
      end

      ST_PUSH: begin
        if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_rv_nxt    = 1'b1;
            out_x0_nxt    = pend_x0_r;
            out_y0_nxt    = pend_y0_r;
            out_x1_nxt    = pend_x1_r;
            out_y1_nxt    = pend_y1_r;
            out_last_nxt  = 1'b0;
            out_hit_nxt   = hit_r;
            out_pw_nxt    = pw_r[req_page_r];
          end
          pend_v_nxt  = 1'b1;
          pend_x0_nxt = {start_r, {CELL_SHIFT{1'b0}}};
          pend_y0_nxt = {scan_row, {CELL_SHIFT{1'b0}}};
          pend_x1_nxt = {col_r, {CELL_SHIFT{1'b0}}};
          pend_y1_nxt = {hrow_r, {CELL_SHIFT{1'b0}}};
          state_nxt   = ST_SCAN_RD;
        end
      end

      ST_FINISH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_rv_nxt    = pend_v_r;
          out_x0_nxt    = pend_v_r ? pend_x0_r : '0;
          out_y0_nxt    = pend_v_r ? pend_y0_r : '0;
          out_x1_nxt    = pend_v_r ? pend_x1_r : '0;
          out_y1_nxt    = pend_v_r ? pend_y1_r : '0;
          out_last_nxt  = 1'b1;
          out_hit_nxt   = hit_r;
          out_pw_nxt    = pw_r[req_page_r];
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      pw_r        <= '0;
      any_dirty_r <= 1'b0;
      hit_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      vp_en_r     <= 1'b0;
      vp_left_r   <= '0;
      vp_top_r    <= '0;
      vp_right_r  <= '0;
      vp_bottom_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      pw_r        <= pw_nxt;
      any_dirty_r <= any_dirty_nxt;
      hit_r       <= hit_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_VP_ENABLE: vp_en_r     <= cfg_data[0];
          REG_VP_LEFT:   vp_left_r   <= cfg_data;
          REG_VP_TOP:    vp_top_r    <= cfg_data;
          REG_VP_RIGHT:  vp_right_r  <= cfg_data;
          REG_VP_BOTTOM: vp_bottom_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd_r    <= in_cmd;
      req_left_r   <= in_rect_left;
      req_top_r    <= in_rect_top;
      req_right_r  <= in_rect_right;
      req_bottom_r <= in_rect_bottom;
      req_flags_r  <= in_mark_flags;
      req_page_r   <= in_page;
      req_cell_r   <= in_cell_index;
      req_occ_r    <= in_occupied_value;
      req_row_r    <= in_row_index;
    end
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    col_r     <= col_nxt;
    start_r   <= start_nxt;
    hrow_r    <= hrow_nxt;
    pend_x0_r <= pend_x0_nxt;
    pend_y0_r <= pend_y0_nxt;
    pend_x1_r <= pend_x1_nxt;
    pend_y1_r <= pend_y1_nxt;
    out_rv_r   <= out_rv_nxt;
    out_x0_r   <= out_x0_nxt;
    out_y0_r   <= out_y0_nxt;
    out_x1_r   <= out_x1_nxt;
    out_y1_r   <= out_y1_nxt;
    out_last_r <= out_last_nxt;
    out_hit_r  <= out_hit_nxt;
    out_pw_r   <= out_pw_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_rect_valid        = out_rv_r;
  assign out_x0                = out_x0_r;
  assign out_y0                = out_y0_r;
  assign out_x1                = out_x1_r;
  assign out_y1                = out_y1_r;
  assign out_last              = out_last_r;
  assign out_viewport_hit      = out_hit_r;
  assign out_page_whole_status = out_pw_r;

endmodule

// ===== bench/tb_dirty_tile_tracker_unit.sv =====
// Self-checking testbench for the dirty tile tracker unit.
`timescale 1ns / 1ps

// Scoreboard: mirrors the tracker's grid and page state and queues the rectangles it owes.
class tile_scoreboard;
  typedef struct packed {
    logic       rect_valid;
    logic [9:0] x0;
    logic [8:0] y0;
    logic [9:0] x1;
    logic [8:0] y1;
    logic       last;
    logic       hit;
    logic       whole;
  } flush_rect_t;

  logic [7:0] cell_bits [dtt_pkg::NCELLS];
  logic       cell_occ [dtt_pkg::NCELLS];
  logic       page_whole [2];
  logic       any_dirty;
  logic       hit_flag;
  logic       vp_en;
  int         vp_l, vp_t, vp_r, vp_b;
  flush_rect_t owed_rects[$];
  int         errors;
  int         rects_seen;

  function new();
    foreach (cell_bits[i]) begin
      cell_bits[i] = '0;
      cell_occ[i] = 1'b0;
    end
    page_whole[0] = 0;
    page_whole[1] = 0;
    any_dirty = 0;
    hit_flag = 0;
    vp_en = 0;
    vp_l = 0; vp_t = 0; vp_r = 0; vp_b = 0;
    errors = 0;
    rects_seen = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [9:0] val);
    case (idx)
      dtt_pkg::REG_VP_ENABLE: vp_en = val[0];
      dtt_pkg::REG_VP_LEFT:   vp_l = int'(val);
      dtt_pkg::REG_VP_TOP:    vp_t = int'(val);
      dtt_pkg::REG_VP_RIGHT:  vp_r = int'(val);
      dtt_pkg::REG_VP_BOTTOM: vp_b = int'(val);
      default: ;
    endcase
  endfunction

  function int clip_lo(int v, int lim);
    if (v < 0) v = 0;
    if (v > lim - 1) v = lim;
    return v;
  endfunction

  function int clip_hi(int v, int lim);
    int t;
    t = v + dtt_pkg::CELL_SIZE - 1;
    if (t <= 0) return 0;
    t = (t / dtt_pkg::CELL_SIZE) * dtt_pkg::CELL_SIZE;
    if (t >= lim) t = lim;
    return t;
  endfunction

  function bit in_span(int v, int lo, int hi);
    return lo <= v && v <= hi;
  endfunction

  function void paint_cell(int c, logic [7:0] flags);
    int l, t;
    if (cell_occ[c]) return;
    cell_bits[c] |= flags | dtt_pkg::DIRTY_BIT;
    any_dirty = 1;
    t = (c / dtt_pkg::GRID_COLS) * dtt_pkg::CELL_SIZE;
    l = (c % dtt_pkg::GRID_COLS) * dtt_pkg::CELL_SIZE;
    if (vp_en && (in_span(l, vp_l, vp_r) || in_span(l + 8, vp_l, vp_r)) &&
        (in_span(t, vp_t, vp_b) || in_span(t + 8, vp_t, vp_b))) begin
      cell_bits[c] |= dtt_pkg::VIEW_BITS;
      hit_flag = 1;
    end
  endfunction

  function void owe(logic v, int x0, int y0, int x1, int y1, logic pg);
    flush_rect_t e;
    e.rect_valid = v;
    e.x0 = 10'(x0); e.y0 = 9'(y0); e.x1 = 10'(x1); e.y1 = 9'(y1);
    e.last = 0;
    e.hit = hit_flag;
    e.whole = page_whole[pg];
    owed_rects.push_back(e);
  endfunction

  // Note an accepted request: update the mirror and queue its results.
  function void note_request(logic [1:0] cmd, int rl, int rt, int rr, int rb,
                             logic [7:0] mf, logic pg, int ci, logic ov, int row);
    int l, t, r, b, x, y, n, col, w, h, base;
    logic [7:0] flags;
    flush_rect_t e;
    n = 0;
    case (cmd)
      dtt_pkg::CMD_MARK: begin
        if (!page_whole[pg]) begin
          l = clip_lo(rl, dtt_pkg::SCR_W);
          t = clip_lo(rt, dtt_pkg::SCR_H);
          r = clip_hi(rr, dtt_pkg::SCR_W);
          b = clip_hi(rb, dtt_pkg::SCR_H);
          if (r - l > 0 && b - t > 0) begin
            if (r - l == dtt_pkg::SCR_W && b - t == dtt_pkg::SCR_H) page_whole[pg] = 1;
            flags = '0;
            if (mf[2]) flags = dtt_pkg::HIGH_FLAG;
            if (mf[0]) flags |= 8'h02;
            for (y = t; y < b; y += 8)
              for (x = l; x < r; x += 8)
                paint_cell(x / 8 + (y / 8) * dtt_pkg::GRID_COLS, flags);
          end
        end
      end
      dtt_pkg::CMD_FLUSH: begin
        if (any_dirty && row < dtt_pkg::GRID_ROWS) begin
          col = 0;
          while (col < dtt_pkg::GRID_COLS && n < 40) begin
            base = row * dtt_pkg::GRID_COLS + col;
            if (!(cell_bits[base] & dtt_pkg::DIRTY_BIT)) begin
              col++;
            end else begin
              w = 0;
              while (col + w < dtt_pkg::GRID_COLS &&
                     (cell_bits[base + w] & dtt_pkg::DIRTY_BIT)) w++;
              h = 0;
              while (row + h < dtt_pkg::GRID_ROWS &&
                     (cell_bits[base + h * dtt_pkg::GRID_COLS] & dtt_pkg::DIRTY_BIT)) h++;
              for (y = 0; y < h; y++)
                for (x = 0; x < w; x++)
                  cell_bits[base + y * dtt_pkg::GRID_COLS + x] &= dtt_pkg::KEEP_MASK;
              owe(1, col * 8, row * 8, (col + w) * 8, (row + h) * 8, pg);
              n++;
              col += w;
            end
          end
          if (row == dtt_pkg::GRID_ROWS - 1) any_dirty = 0;
        end
      end
      dtt_pkg::CMD_SET_OCC: if (ci < dtt_pkg::NCELLS) cell_occ[ci] = ov;
      default: page_whole[pg] = 0;
    endcase
    if (n == 0) owe(0, 0, 0, 0, 0, pg);
    e = owed_rects.pop_back();
    e.last = 1;
    owed_rects.push_back(e);
  endfunction

  task report(string what, int got, int want);
    $display("mismatch on %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Compare one accepted result with the oldest owed one.
  task check_result(flush_rect_t got);
    flush_rect_t want;
    if (owed_rects.size() == 0) begin
      report("result count", owed_rects.size() + 1, owed_rects.size());
      return;
    end
    want = owed_rects.pop_front();
    if (got.rect_valid) rects_seen++;
    if (got.rect_valid !== want.rect_valid) report("rect_valid", got.rect_valid, want.rect_valid);
    if (got.x0 !== want.x0) report("x0", got.x0, want.x0);
    if (got.y0 !== want.y0) report("y0", got.y0, want.y0);
    if (got.x1 !== want.x1) report("x1", got.x1, want.x1);
    if (got.y1 !== want.y1) report("y1", got.y1, want.y1);
    if (got.last !== want.last) report("last", got.last, want.last);
    if (got.hit !== want.hit) report("viewport_hit", got.hit, want.hit);
    if (got.whole !== want.whole) report("page_whole_status", got.whole, want.whole);
  endtask
endclass

module tb_dirty_tile_tracker_unit;
  import dtt_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_cmd = '0;
  logic signed [15:0] in_rect_left = '0, in_rect_top = '0, in_rect_right = '0;
  logic signed [15:0] in_rect_bottom = '0;
  logic [7:0] in_mark_flags = '0;
  logic in_page = 0;
  logic [12:0] in_cell_index = '0;
  logic in_occupied_value = 0;
  logic [5:0] in_row_index = '0;
  logic out_valid;
  logic out_ready = 0;
  logic out_rect_valid, out_last, out_viewport_hit, out_page_whole_status;
  logic [9:0] out_x0, out_x1;
  logic [8:0] out_y0, out_y1;
  logic cfg_wr_en = 0;
  logic [2:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;

  tile_scoreboard board = new();
  bit quiet_tail = 0;      // drop all idling near the end
  bit hold_off = 0;        // receiver holds off for a long stretch
  int requests_sent = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  dirty_tile_tracker_unit u_top (.*);

  // Safety net: even the slowest legal run finishes far earlier.
  initial begin
    #(8 * 10000000);
    $display("TB_ERROR");
    $finish;
  end

  // Check every result accepted at a clock edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result({out_rect_valid, out_x0, out_y0, out_x1, out_y1, out_last,
                          out_viewport_hit, out_page_whole_status});
  end

  // Receiver: stall in random bursts, or hold off completely while asked to.
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 10);
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, int val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= 10'(val);
    board.write_reg(idx, 10'(val));
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  // Offer one request and hold it until the block takes it; valid drops only on idling.
  task automatic send(logic [1:0] cmd, logic [15:0] l, logic [15:0] t, logic [15:0] r,
                      logic [15:0] b, logic [7:0] mf, logic pg, logic [12:0] ci,
                      logic ov, logic [5:0] row);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_cmd <= cmd;
    in_rect_left <= l; in_rect_top <= t; in_rect_right <= r; in_rect_bottom <= b;
    in_mark_flags <= mf; in_page <= pg; in_cell_index <= ci;
    in_occupied_value <= ov; in_row_index <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(cmd, $signed(l), $signed(t), $signed(r), $signed(b), mf, pg,
                       int'(ci), ov, int'(row));
    requests_sent++;
  endtask

  task automatic mark(int l, int t, int r, int b, logic [7:0] mf, logic pg);
    send(CMD_MARK, 16'(l), 16'(t), 16'(r), 16'(b), mf, pg, 13'($urandom), 1'($urandom),
         6'($urandom));
  endtask

  task automatic flush(int row, logic pg);
    send(CMD_FLUSH, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
         8'($urandom), pg, 13'($urandom), 1'($urandom), 6'(row));
  endtask

  // Wait for every owed result, then let the block settle before touching registers.
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (board.owed_rects.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic random_request();
    int pick, l, t;
    pick = $urandom_range(0, 99);
    l = $urandom_range(0, 700) - 40;
    t = $urandom_range(0, 520) - 40;
    if (pick < 45) begin
      // mostly small rectangles, keep marks short
      mark(l, t, l + $urandom_range(0, 48), t + $urandom_range(0, 40), 8'($urandom),
           1'($urandom));
    end else if (pick < 50) begin
      mark($urandom, $urandom, $urandom, $urandom, 8'($urandom), 1'($urandom));
    end else if (pick < 80) begin
      flush($urandom_range(0, 63), 1'($urandom));
    end else if (pick < 92) begin
      send(CMD_SET_OCC, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           8'($urandom), 1'($urandom),
           13'($urandom_range(0, 8191) % ($urandom_range(0, 1) ? 8192 : 4800)),
           1'($urandom), 6'($urandom));
    end else begin
      send(CMD_PAGE_CLR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           8'($urandom), 1'($urandom), 13'($urandom), 1'($urandom), 6'($urandom));
    end
  endtask

  initial begin
    int i;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    // the block clears its grid before the first request; handshakes cover that

    // Directed: viewport on over a strip along the left edge of the screen.
    write_reg(REG_VP_ENABLE, 1);
    write_reg(REG_VP_LEFT, 0);
    write_reg(REG_VP_TOP, 0);
    write_reg(REG_VP_RIGHT, 20);
    write_reg(REG_VP_BOTTOM, 1023);
    flush(0, 1'b0);                                   // nothing dirty: no scan
    mark(3, 5, 21, 14, 8'h05, 1'b0);                  // unaligned edges
    mark(-32768, -32768, 32767, -32768, 8'hff, 1'b0); // clipped away
    mark(100, 100, 100, 200, 8'h00, 1'b1);            // zero width, still covers one cell column
    mark(640, 480, 32767, 32767, 8'h00, 1'b1);        // beyond the screen
    send(CMD_SET_OCC, '0, '0, '0, '0, '0, 1'b0, 13'd82, 1'b1, '0);
    send(CMD_SET_OCC, '0, '0, '0, '0, '0, 1'b1, 13'h1fff, 1'b1, '0);   // out of range
    mark(8, 0, 40, 24, 8'h01, 1'b1);                  // skips the occupied cell
    flush(0, 1'b0);
    flush(1, 1'b1);
    flush(63, 1'b0);                                  // row out of range
    mark(0, 472, 640, 480, 8'h04, 1'b0);
    flush(59, 1'b0);                                  // clears any_dirty
    flush(2, 1'b0);
    mark(-5, -5, 700, 500, 8'h00, 1'b1);              // whole screen sets page-whole
    mark(0, 0, 8, 8, 8'h04, 1'b1);                    // ignored on that page
    send(CMD_PAGE_CLR, '0, '0, '0, '0, '0, 1'b1, '0, 1'b0, '0);
    mark(32767, 32767, -32768, -32768, 8'haa, 1'b1);
    flush(7, 1'b1);
    send(CMD_SET_OCC, '0, '0, '0, '0, '0, 1'b0, 13'd82, 1'b0, '0);
    drain();

    // Viewport at the far extremes, then disabled with odd edges.
    write_reg(REG_VP_LEFT, 1023);
    write_reg(REG_VP_TOP, 1023);
    write_reg(REG_VP_RIGHT, 1023);
    write_reg(REG_VP_BOTTOM, 1023);
    for (i = 0; i < 20; i++) random_request();

    // Hold the receiver off while requests keep coming so the block backs up.
    hold_off = 1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      for (i = 0; i < 10; i++) flush($urandom_range(0, 59), 1'($urandom));
    join
    drain();

    write_reg(REG_VP_ENABLE, 0);
    write_reg(REG_VP_LEFT, 200);
    write_reg(REG_VP_TOP, 100);
    write_reg(REG_VP_RIGHT, 400);
    write_reg(REG_VP_BOTTOM, 300);
    for (i = 0; i < 20; i++) random_request();
    drain();

    write_reg(REG_VP_ENABLE, 1);
    for (i = 0; i < 15; i++) random_request();
    quiet_tail = 1;
    for (i = 0; i < 10; i++) random_request();
    for (i = 0; i < 60; i += 3) flush(i, 1'b0);
    in_valid <= 0;

    i = 0;
    while (board.owed_rects.size() != 0 && i < 200000) begin
      @(posedge clk);
      i++;
    end
    repeat (100) @(posedge clk);
    $display("covered %0d requests, %0d coalesced rectangles, several viewport settings",
             requests_sent, board.rects_seen);
    if (board.errors == 0 && board.owed_rects.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d results still owed", board.owed_rects.size());
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
